// ----- hw/rtl/i2crts_pkg.sv -----
package i2crts_pkg;

    localparam int BUF_DEPTH = 32;
    localparam int BUF_AW    = $clog2(BUF_DEPTH);
    localparam int CNT_W     = 6;

    typedef enum logic [1:0] {
        CMD_LOAD     = 2'd0,
        CMD_START_WR = 2'd1,
        CMD_START_RD = 2'd2,
        CMD_STEP     = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ACT_NONE    = 3'd0,
        ACT_START   = 3'd1,
        ACT_SEND    = 3'd2,
        ACT_RX_ACK  = 3'd3,
        ACT_RX_NACK = 3'd4,
        ACT_STOP    = 3'd5
    } action_t;

    typedef enum logic [1:0] {
        MODE_NONE  = 2'd0,
        MODE_WRITE = 2'd1,
        MODE_READ  = 2'd2
    } mode_t;

    typedef enum logic [3:0] {
        PH_IDLE    = 4'd0,
        PH_START   = 4'd1,
        PH_ADDR_W  = 4'd2,
        PH_WDATA   = 4'd3,
        PH_WORD_R  = 4'd4,
        PH_RESTART = 4'd5,
        PH_ADDR_R  = 4'd6,
        PH_RX_ACK  = 4'd7,
        PH_RX_NACK = 4'd8
    } phase_t;

    // write and read requests to the write buffer
    typedef struct packed {
        logic              en;
        logic [BUF_AW-1:0] addr;
        logic [7:0]        data;
    } wbuf_wr_t;

    typedef struct packed {
        logic              en;
        logic [BUF_AW-1:0] addr;
    } wbuf_rd_t;

endpackage

// ----- hw/rtl/i2c_register_transfer_sequencer.sv -----
// A word's result is registered in the output stage when the word is accepted.
// Throughput: one word per cycle while the output stage is not stalled; the write
// buffer read is issued at accept time and its registered data feeds tx_byte from the output stage.
// s_ready drops only while a result is held and m_ready is low.
// Reset (aresetn low, synchronous) idles the sequencer and empties the output
// stage; write buffer contents are undefined until loaded.
module i2c_register_transfer_sequencer (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [1:0]                    s_cmd,
    input  logic [6:0]                    s_slave_addr,
    input  logic [7:0]                    s_word_addr,
    input  logic [i2crts_pkg::CNT_W-1:0]  s_byte_count,
    input  logic [i2crts_pkg::BUF_AW-1:0] s_load_index,
    input  logic [7:0]                    s_load_byte,
    input  logic [7:0]                    s_rx_byte,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [2:0]                    m_action,
    output logic [7:0]                    m_tx_byte,
    output logic                          m_read_valid,
    output logic [i2crts_pkg::BUF_AW-1:0] m_read_index,
    output logic [7:0]                    m_read_byte,
    output logic                          m_write_done,
    output logic                          m_read_done,
    output logic                          m_busy_res
);
    import i2crts_pkg::*;

    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(BUF_DEPTH);

    phase_t            phase_reg, phase_next;
    mode_t             mode_reg, mode_next;
    logic [CNT_W-1:0]  byte_index_reg, byte_index_next;
    logic [6:0]        held_slave_reg, held_slave_next;
    logic [7:0]        held_word_reg, held_word_next;
    logic [CNT_W-1:0]  held_count_reg, held_count_next;

    logic              accept;
    cmd_t              cmd;
    logic [CNT_W-1:0]  index_inc;
    logic              more_now, more_inc, wdata_left;

    action_t           action_c;
    logic [7:0]        tx_c;
    logic              sel_mem_c, rv_c, wr_done_c, rd_done_c;
    logic [BUF_AW-1:0] ridx_c;
    logic [7:0]        rbyte_c;

    logic              m_valid_reg;
    action_t           action_reg;
    logic [7:0]        tx_reg;
    logic              sel_mem_reg, rv_reg, wr_done_reg, rd_done_reg, busy_reg;
    logic [BUF_AW-1:0] ridx_reg;
    logic [7:0]        rbyte_reg;

    wbuf_wr_t          buf_wr;
    wbuf_rd_t          buf_rd;
    logic [7:0]        buf_rdata;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign cmd     = cmd_t'(s_cmd);

    assign index_inc  = byte_index_reg + CNT_W'(1);
    // another byte still follows the current receive position
    assign more_now   = ({1'b0, byte_index_reg} + (CNT_W+1)'(1)) < {1'b0, held_count_reg};
    assign more_inc   = ({1'b0, index_inc} + (CNT_W+1)'(1)) < {1'b0, held_count_reg};
    assign wdata_left = (byte_index_reg < held_count_reg) && (byte_index_reg < DEPTH_CNT);

    // next state
    always_comb begin
        phase_next      = phase_reg;
        mode_next       = mode_reg;
        byte_index_next = byte_index_reg;
        held_slave_next = held_slave_reg;
        held_word_next  = held_word_reg;
        held_count_next = held_count_reg;
        unique case (cmd)
            CMD_LOAD: begin
            end
            CMD_START_WR, CMD_START_RD: begin
                if (phase_reg == PH_IDLE) begin
                    held_slave_next = s_slave_addr;
                    held_word_next  = s_word_addr;
                    held_count_next = (s_byte_count > DEPTH_CNT) ? DEPTH_CNT : s_byte_count;
                    mode_next       = (cmd == CMD_START_WR) ? MODE_WRITE : MODE_READ;
                    byte_index_next = '0;
                    phase_next      = PH_START;
                end
            end
            CMD_STEP: begin
                unique case (phase_reg)
                    PH_IDLE: begin
                    end
                    PH_START:   phase_next = PH_ADDR_W;
                    PH_ADDR_W: begin
                        byte_index_next = '0;
                        phase_next = (mode_reg == MODE_WRITE) ? PH_WDATA : PH_WORD_R;
                    end
                    PH_WDATA: begin
                        if (wdata_left) begin
                            byte_index_next = index_inc;
                        end else begin
                            phase_next      = PH_IDLE;
                            mode_next       = MODE_NONE;
                            byte_index_next = '0;
                        end
                    end
                    PH_WORD_R:  phase_next = PH_RESTART;
                    PH_RESTART: phase_next = PH_ADDR_R;
                    PH_ADDR_R: begin
                        if (held_count_reg == '0) begin
                            phase_next      = PH_IDLE;
                            mode_next       = MODE_NONE;
                            byte_index_next = '0;
                        end else begin
                            phase_next = more_now ? PH_RX_ACK : PH_RX_NACK;
                        end
                    end
                    PH_RX_ACK: begin
                        if (held_count_reg == '0) begin
                            phase_next      = PH_IDLE;
                            mode_next       = MODE_NONE;
                            byte_index_next = '0;
                        end else begin
                            byte_index_next = index_inc;
                            phase_next      = more_inc ? PH_RX_ACK : PH_RX_NACK;
                        end
                    end
                    default: begin
                        // final byte, and any unused phase code
                        phase_next      = PH_IDLE;
                        mode_next       = MODE_NONE;
                        byte_index_next = '0;
                    end
                endcase
            end
            default: begin
            end
        endcase
    end

    // result fields
    always_comb begin
        action_c  = ACT_NONE;
        tx_c      = '0;
        sel_mem_c = 1'b0;
        rv_c      = 1'b0;
        ridx_c    = '0;
        rbyte_c   = '0;
        wr_done_c = 1'b0;
        rd_done_c = 1'b0;
        unique case (cmd)
            CMD_LOAD: begin
            end
            CMD_START_WR, CMD_START_RD: begin
                if (phase_reg == PH_IDLE) begin
                    action_c = ACT_START;
                end
            end
            CMD_STEP: begin
                unique case (phase_reg)
                    PH_IDLE: begin
                    end
                    PH_START: begin
                        action_c = ACT_SEND;
                        tx_c     = {held_slave_reg, 1'b0};
                    end
                    PH_ADDR_W: begin
                        action_c = ACT_SEND;
                        tx_c     = held_word_reg;
                    end
                    PH_WDATA: begin
                        if (wdata_left) begin
                            action_c  = ACT_SEND;
                            sel_mem_c = 1'b1;
                        end else begin
                            action_c  = ACT_STOP;
                            wr_done_c = 1'b1;
                        end
                    end
                    PH_WORD_R:  action_c = ACT_START;
                    PH_RESTART: begin
                        action_c = ACT_SEND;
                        tx_c     = {held_slave_reg, 1'b1};
                    end
                    PH_ADDR_R: begin
                        if (held_count_reg == '0) begin
                            action_c  = ACT_STOP;
                            rd_done_c = 1'b1;
                        end else begin
                            action_c = more_now ? ACT_RX_ACK : ACT_RX_NACK;
                        end
                    end
                    PH_RX_ACK: begin
                        rv_c    = 1'b1;
                        ridx_c  = byte_index_reg[BUF_AW-1:0];
                        rbyte_c = s_rx_byte;
                        if (held_count_reg == '0) begin
                            action_c  = ACT_STOP;
                            rd_done_c = 1'b1;
                        end else begin
                            action_c = more_inc ? ACT_RX_ACK : ACT_RX_NACK;
                        end
                    end
                    PH_RX_NACK: begin
                        rv_c      = 1'b1;
                        ridx_c    = byte_index_reg[BUF_AW-1:0];
                        rbyte_c   = s_rx_byte;
                        action_c  = ACT_STOP;
                        rd_done_c = 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        buf_wr.en   = accept && (cmd == CMD_LOAD);
        buf_wr.addr = s_load_index;
        buf_wr.data = s_load_byte;
        buf_rd.en   = accept && sel_mem_c;
        buf_rd.addr = byte_index_reg[BUF_AW-1:0];
    end

    i2crts_wbuf u_wbuf (
        .aclk    (aclk),
        .wr      (buf_wr),
        .rd      (buf_rd),
        .rd_data (buf_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_IDLE;
            mode_reg       <= MODE_NONE;
            byte_index_reg <= '0;
            held_slave_reg <= '0;
            held_word_reg  <= '0;
            held_count_reg <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (accept) begin
                phase_reg      <= phase_next;
                mode_reg       <= mode_next;
                byte_index_reg <= byte_index_next;
                held_slave_reg <= held_slave_next;
                held_word_reg  <= held_word_next;
                held_count_reg <= held_count_next;
                m_valid_reg    <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            action_reg  <= action_c;
            tx_reg      <= tx_c;
            sel_mem_reg <= sel_mem_c;
            rv_reg      <= rv_c;
            ridx_reg    <= ridx_c;
            rbyte_reg   <= rbyte_c;
            wr_done_reg <= wr_done_c;
            rd_done_reg <= rd_done_c;
            busy_reg    <= (phase_next != PH_IDLE);
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_action     = action_reg;
    assign m_tx_byte    = sel_mem_reg ? buf_rdata : tx_reg;
    assign m_read_valid = rv_reg;
    assign m_read_index = ridx_reg;
    assign m_read_byte  = rbyte_reg;
    assign m_write_done = wr_done_reg;
    assign m_read_done  = rd_done_reg;
    assign m_busy_res   = busy_reg;

    a_ready_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid_reg)
        else $error("input stalled with empty output stage");

    a_done_ends_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && (wr_done_reg || rd_done_reg) |-> !busy_reg && action_reg == ACT_STOP)
        else $error("finished word without stop or still busy");

    a_idle_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_IDLE |-> mode_reg == MODE_NONE && byte_index_reg == '0)
        else $error("idle phase with stale transfer state");

    a_read_word_action: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && rv_reg |-> action_reg == ACT_STOP || action_reg == ACT_RX_ACK
                                  || action_reg == ACT_RX_NACK)
        else $error("received byte with unexpected action");

    a_mem_send_only: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && sel_mem_reg |-> action_reg == ACT_SEND && mode_reg == MODE_WRITE
                                       || action_reg == ACT_SEND && phase_reg == PH_IDLE)
        else $error("buffer byte selected outside a write send");

endmodule

// ----- hw/rtl/i2crts_wbuf.sv -----
module i2crts_wbuf (
    input  logic                 aclk,
    input  i2crts_pkg::wbuf_wr_t wr,
    input  i2crts_pkg::wbuf_rd_t rd,
    output logic [7:0]           rd_data
);
    import i2crts_pkg::*;

    logic [7:0] mem [BUF_DEPTH];

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
    end

    // read data holds until the next read, so it can sit in the output stage
    always_ff @(posedge aclk) begin
        if (rd.en) begin
            rd_data <= mem[rd.addr];
        end
    end

endmodule
